@@ rtl/bams_pkg.sv @@
package bams_pkg;

    localparam int COORD_W    = 16;
    localparam int TEX_W      = 8;
    localparam int ALPHA_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int COV_W      = 16;
    localparam int FRAC_W     = 15;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int ONE_Q15    = 32768;
    localparam int HALF_RANGE = 16384;

    // Four banks split by column and row parity.
    localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int TOP_W  = ALPHA_W + FRAC_W;
    localparam int R_W    = TOP_W + FRAC_W;
    localparam int Q_W    = R_W - FRAC_W;

    // floor(q / 255) = (q * RECIP) >> RECIP_SHIFT, exact for q < 2^23
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0] RECIP = 24'd8421505;
    localparam int PROD_W = Q_W + RECIP_W;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

endpackage

@@ rtl/bilinear_alpha_mask_sampler_core.sv @@
// A sample word's coverage passes through the pipeline stage registers and leaves
// from the output register together with its strobe.
// Throughput: one word per cycle, writes and samples mixed freely; busy stays low.
// Each sample reads its four texels in the same cycle from four parity-split RAM banks.
// The receiver cannot stall; every result is on the ports for one cycle only.
// Synchronous active-low reset clears configuration and pipeline valids; the
// alpha store is not cleared and holds garbage until texels are written.
module bilinear_alpha_mask_sampler_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_op,
    input  logic [bams_pkg::TEX_W-1:0]           i_texel_x,
    input  logic [bams_pkg::TEX_W-1:0]           i_texel_y,
    input  logic [bams_pkg::ALPHA_W-1:0]         i_texel_alpha,
    input  logic signed [bams_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [bams_pkg::COORD_W-1:0]  i_coord_y,
    output logic                                 o_strobe,
    output logic [bams_pkg::COV_W-1:0]           o_coverage,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bams_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bams_pkg::SIZE_W-1:0]          i_cfg_data
);

    import bams_pkg::*;

    function automatic logic [COORD_W-1:0] sat_u(input logic signed [COORD_W-1:0] c);
        logic signed [COORD_W:0] t;
        logic [COORD_W-1:0]      u;
        t = c;
        t = t + (COORD_W+1)'(HALF_RANGE);
        if (t < 0) begin
            u = '0;
        end else if (t > (COORD_W+1)'(ONE_Q15)) begin
            u = COORD_W'(ONE_Q15);
        end else begin
            u = t[COORD_W-1:0];
        end
        return u;
    endfunction

    // configuration
    logic              r_mask_enabled;
    logic [SIZE_W-1:0] r_mask_width;
    logic [SIZE_W-1:0] r_mask_height;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_enabled <= 1'b0;
            r_mask_width   <= '0;
            r_mask_height  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ENABLE: r_mask_enabled <= i_cfg_data[0];
                REG_WIDTH:  r_mask_width   <= i_cfg_data;
                REG_HEIGHT: r_mask_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [SIZE_W-1:0] w_m1;
    logic [SIZE_W-1:0] h_m1;
    logic              size_zero;

    assign w_eff = (r_mask_width  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : r_mask_width;
    assign h_eff = (r_mask_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : r_mask_height;
    assign w_m1  = w_eff - 1'b1;
    assign h_m1  = h_eff - 1'b1;
    assign size_zero = (w_eff == '0) || (h_eff == '0);

    // stage 1: saturate and offset coordinates
    logic                r_v1;
    logic                r_op1;
    logic [TEX_W-1:0]    r_wx1, r_wy1;
    logic [ALPHA_W-1:0]  r_wa1;
    logic [COORD_W-1:0]  r_ux1, r_uy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start && !o_busy;
        end
        r_op1 <= i_op;
        r_wx1 <= i_texel_x;
        r_wy1 <= i_texel_y;
        r_wa1 <= i_texel_alpha;
        r_ux1 <= sat_u(i_coord_x);
        r_uy1 <= sat_u(i_coord_y);
    end

    // stage 2: scale by size-1, split integer and fraction
    logic [COORD_W+TEX_W-1:0] n_px, n_py;

    assign n_px = r_ux1 * w_m1[TEX_W-1:0];
    assign n_py = r_uy1 * h_m1[TEX_W-1:0];

    logic                r_v2;
    logic                r_op2;
    logic [TEX_W-1:0]    r_wx2, r_wy2;
    logic [ALPHA_W-1:0]  r_wa2;
    logic [TEX_W-1:0]    r_x02, r_y02;
    logic [FRAC_W-1:0]   r_tx2, r_ty2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_op2 <= r_op1;
        r_wx2 <= r_wx1;
        r_wy2 <= r_wy1;
        r_wa2 <= r_wa1;
        r_x02 <= n_px[FRAC_W+TEX_W-1:FRAC_W];
        r_y02 <= n_py[FRAC_W+TEX_W-1:FRAC_W];
        r_tx2 <= n_px[FRAC_W-1:0];
        r_ty2 <= n_py[FRAC_W-1:0];
    end

    // The neighbour read is always x0+1; at the last column or row the
    // neighbour is taken as the texel itself and that read is discarded.
    logic [TEX_W-1:0] x1, y1;
    logic [TEX_W-1:0] col_sel [2];
    logic [TEX_W-1:0] row_sel [2];
    logic             bank_we;
    logic             x_edge, y_edge;

    assign x1 = r_x02 + 1'b1;
    assign y1 = r_y02 + 1'b1;
    assign col_sel[0] = r_x02[0] ? x1 : r_x02;
    assign col_sel[1] = r_x02[0] ? r_x02 : x1;
    assign row_sel[0] = r_y02[0] ? y1 : r_y02;
    assign row_sel[1] = r_y02[0] ? r_y02 : y1;
    assign bank_we    = r_v2 && (r_op2 == OP_WRITE);
    assign x_edge     = ({1'b0, r_x02} == w_m1);
    assign y_edge     = ({1'b0, r_y02} == h_m1);

    logic [ALPHA_W-1:0] bank_q [2][2];

    for (genvar by = 0; by < 2; by++) begin : g_row
        for (genvar bx = 0; bx < 2; bx++) begin : g_col
            bams_ram #(
                .WIDTH (ALPHA_W),
                .DEPTH (BANK_DEPTH)
            ) u_bank (
                .i_clk   (i_clk),
                .i_we    (bank_we && (r_wy2[0] == 1'(by)) && (r_wx2[0] == 1'(bx))),
                .i_waddr ({r_wy2[TEX_W-1:1], r_wx2[TEX_W-1:1]}),
                .i_wdata (r_wa2),
                .i_raddr ({row_sel[by][TEX_W-1:1], col_sel[bx][TEX_W-1:1]}),
                .o_rdata (bank_q[by][bx])
            );
        end
    end

    // stage 3: texels out of the banks
    logic              r_v3;
    logic              r_op3;
    logic              r_xp3, r_yp3;
    logic              r_xe3, r_ye3;
    logic [FRAC_W-1:0] r_tx3, r_ty3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_op3 <= r_op2;
        r_xp3 <= r_x02[0];
        r_yp3 <= r_y02[0];
        r_xe3 <= x_edge;
        r_ye3 <= y_edge;
        r_tx3 <= r_tx2;
        r_ty3 <= r_ty2;
    end

    // stage 4: horizontal lerps
    logic [ALPHA_W-1:0]          q00, q10, q01, q11;
    logic [ALPHA_W-1:0]          a00, a10, a01, a11;
    logic signed [ALPHA_W:0]     d_top, d_bot;
    logic signed [TOP_W+1:0]     n_top, n_bot;

    assign q00 = bank_q[r_yp3][r_xp3];
    assign q10 = bank_q[r_yp3][~r_xp3];
    assign q01 = bank_q[~r_yp3][r_xp3];
    assign q11 = bank_q[~r_yp3][~r_xp3];

    assign a00 = q00;
    assign a10 = r_xe3 ? q00 : q10;
    assign a01 = r_ye3 ? q00 : q01;
    assign a11 = r_xe3 ? a01 : (r_ye3 ? q10 : q11);

    assign d_top = $signed({1'b0, a10}) - $signed({1'b0, a00});
    assign d_bot = $signed({1'b0, a11}) - $signed({1'b0, a01});
    assign n_top = $signed({2'b00, a00, {FRAC_W{1'b0}}}) + d_top * $signed({1'b0, r_tx3});
    assign n_bot = $signed({2'b00, a01, {FRAC_W{1'b0}}}) + d_bot * $signed({1'b0, r_tx3});

    logic              r_v4;
    logic              r_op4;
    logic [TOP_W-1:0]  r_top4, r_bot4;
    logic [FRAC_W-1:0] r_ty4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_op4  <= r_op3;
        r_top4 <= n_top[TOP_W-1:0];
        r_bot4 <= n_bot[TOP_W-1:0];
        r_ty4  <= r_ty3;
    end

    // stage 5: vertical lerp
    logic signed [TOP_W:0] d_vert;
    logic signed [R_W+1:0] n_r;

    assign d_vert = $signed({1'b0, r_bot4}) - $signed({1'b0, r_top4});
    assign n_r    = $signed({2'b00, r_top4, {FRAC_W{1'b0}}}) + d_vert * $signed({1'b0, r_ty4});

    logic           r_v5;
    logic           r_op5;
    logic [R_W-1:0] r_r5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_op5 <= r_op4;
        r_r5  <= n_r[R_W-1:0];
    end

    // stage 6: divide by 255 through the reciprocal
    logic              r_v6;
    logic              r_op6;
    logic [PROD_W-1:0] r_prod6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_op6   <= r_op5;
        r_prod6 <= r_r5[R_W-1:FRAC_W] * RECIP;
    end

    // stage 7: clamp, special cases, output register
    logic [PROD_W-RECIP_SHIFT-1:0] cov_raw;
    logic [COV_W-1:0]              n_cov;

    assign cov_raw = r_prod6[PROD_W-1:RECIP_SHIFT];

    always_comb begin
        priority if (!r_mask_enabled) begin
            n_cov = COV_W'(ONE_Q15);
        end else if (size_zero) begin
            n_cov = '0;
        end else if (cov_raw > (PROD_W-RECIP_SHIFT)'(ONE_Q15)) begin
            n_cov = COV_W'(ONE_Q15);
        end else begin
            n_cov = cov_raw[COV_W-1:0];
        end
    end

    logic             r_strobe;
    logic [COV_W-1:0] r_coverage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v6 && (r_op6 == OP_SAMPLE);
        end
        r_coverage <= n_cov;
    end

    assign o_strobe   = r_strobe;
    assign o_coverage = r_coverage;

endmodule

@@ rtl/bams_ram.sv @@
module bams_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bams_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEM_TARGET  = 1450;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTS   = 200;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        t_op                        op;
        logic [TEX_W-1:0]           tx;
        logic [TEX_W-1:0]           ty;
        logic [ALPHA_W-1:0]         alpha;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
    } t_mask_word;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_start = 1'b0;
    logic                        o_busy;
    logic                        i_op = 1'b0;
    logic [TEX_W-1:0]            i_texel_x = '0;
    logic [TEX_W-1:0]            i_texel_y = '0;
    logic [ALPHA_W-1:0]          i_texel_alpha = '0;
    logic signed [COORD_W-1:0]   i_coord_x = '0;
    logic signed [COORD_W-1:0]   i_coord_y = '0;
    logic                        o_strobe;
    logic [COV_W-1:0]            o_coverage;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [SIZE_W-1:0]           i_cfg_data = '0;

    bilinear_alpha_mask_sampler_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_texel_x     (i_texel_x),
        .i_texel_y     (i_texel_y),
        .i_texel_alpha (i_texel_alpha),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .o_strobe      (o_strobe),
        .o_coverage    (o_coverage),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the block: configuration and alpha store
    logic                mask_on = 1'b0;
    logic [SIZE_W-1:0]   mask_w = '0;
    logic [SIZE_W-1:0]   mask_h = '0;
    logic [ALPHA_W-1:0]  alpha_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
    bit                  texel_set [0:MAX_WIDTH*MAX_HEIGHT-1];

    t_mask_word          word_q [$];
    logic [COV_W-1:0]    cov_due [$];
    t_mask_word          cur_word;
    int                  words_queued = 0;
    int                  words_taken = 0;
    int                  idle_left = 0;
    int                  gap_mode = 0;
    int                  faults = 0;
    int                  cycle_count = 0;

    function automatic int clamp_size(logic [SIZE_W-1:0] n);
        return (n < MAX_WIDTH) ? int'(n) : MAX_WIDTH;
    endfunction

    // Texel pair and fraction along one axis of an n-texel mask
    function automatic void axis_pos(input logic signed [COORD_W-1:0] c, input int n,
                                     output int i0, output int i1, output int frac);
        int v;
        int p;
        v = int'(c);
        if (v < -HALF_RANGE) v = -HALF_RANGE;
        if (v > HALF_RANGE) v = HALF_RANGE;
        p = (v + HALF_RANGE) * (n - 1);
        i0 = p >> FRAC_W;
        if (i0 > n - 1) i0 = n - 1;
        i1 = (i0 + 1 < n) ? i0 + 1 : n - 1;
        frac = p & ((1 << FRAC_W) - 1);
    endfunction

    function automatic logic [COV_W-1:0] bilinear_cov(logic signed [COORD_W-1:0] cx,
                                                      logic signed [COORD_W-1:0] cy);
        int w, h, x0, x1, y0, y1, tx, ty;
        longint a00, a10, a01, a11, top, bot, r, q;
        if (!mask_on) return COV_W'(ONE_Q15);
        w = clamp_size(mask_w);
        h = clamp_size(mask_h);
        if (w == 0 || h == 0) return '0;
        axis_pos(cx, w, x0, x1, tx);
        axis_pos(cy, h, y0, y1, ty);
        a00 = alpha_mem[y0 * MAX_WIDTH + x0];
        a10 = alpha_mem[y0 * MAX_WIDTH + x1];
        a01 = alpha_mem[y1 * MAX_WIDTH + x0];
        a11 = alpha_mem[y1 * MAX_WIDTH + x1];
        top = a00 * ONE_Q15 + (a10 - a00) * longint'(tx);
        bot = a01 * ONE_Q15 + (a11 - a01) * longint'(tx);
        r = top * ONE_Q15 + (bot - top) * longint'(ty);
        if (r < 0) r = 0;
        q = r / (longint'(255) * ONE_Q15);
        if (q > ONE_Q15) q = ONE_Q15;
        return COV_W'(q);
    endfunction

    task automatic mask_step(input t_mask_word w);
        if (w.op == OP_WRITE) begin
            alpha_mem[int'(w.ty) * MAX_WIDTH + int'(w.tx)] = w.alpha;
        end else begin
            cov_due.push_back(bilinear_cov(w.cx, w.cy));
        end
    endtask

    task automatic report_fault(input string msg);
        faults++;
        if (faults <= MAX_PRINTS) $display("%0t ns: %s", $time, msg);
    endtask

    function automatic int draw_idle();
        case (gap_mode)
            0: return 0;
            1: return $urandom_range(0, 13);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] draw_alpha();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return ALPHA_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] draw_coord();
        int marks [7] = '{-HALF_RANGE, HALF_RANGE, -HALF_RANGE - 1, HALF_RANGE + 1,
                          -32768, 32767, 0};
        case ($urandom_range(0, 9))
            0, 1: return COORD_W'($urandom);
            2: return COORD_W'(marks[$urandom_range(0, 6)]);
            default: return COORD_W'(int'($urandom_range(0, 2 * HALF_RANGE)) - HALF_RANGE);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] draw_size();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return SIZE_W'(1);
            2, 3: return SIZE_W'($urandom_range(255, 256));
            4: return SIZE_W'($urandom_range(257, 511));
            default: return SIZE_W'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic void push_word(t_mask_word w);
        word_q.push_back(w);
        words_queued++;
    endfunction

    function automatic void push_write(logic [TEX_W-1:0] x, logic [TEX_W-1:0] y,
                                       logic [ALPHA_W-1:0] a);
        t_mask_word w;
        w.op = OP_WRITE;
        w.tx = x;
        w.ty = y;
        w.alpha = a;
        w.cx = COORD_W'($urandom);
        w.cy = COORD_W'($urandom);
        texel_set[int'(y) * MAX_WIDTH + int'(x)] = 1'b1;
        push_word(w);
    endfunction

    // With the mask on and sized, a sample is preceded by writes of any of its four texels not yet loaded
    function automatic void push_sample(logic signed [COORD_W-1:0] cx,
                                        logic signed [COORD_W-1:0] cy);
        t_mask_word w;
        int wd, ht, x0, x1, y0, y1, tx, ty, xx, yy;
        wd = clamp_size(mask_w);
        ht = clamp_size(mask_h);
        if (mask_on && wd != 0 && ht != 0) begin
            axis_pos(cx, wd, x0, x1, tx);
            axis_pos(cy, ht, y0, y1, ty);
            for (int j = 0; j < 4; j++) begin
                xx = j[0] ? x1 : x0;
                yy = j[1] ? y1 : y0;
                if (!texel_set[yy * MAX_WIDTH + xx]) push_write(TEX_W'(xx), TEX_W'(yy), draw_alpha());
            end
        end
        w.op = OP_SAMPLE;
        w.tx = TEX_W'($urandom);
        w.ty = TEX_W'($urandom);
        w.alpha = ALPHA_W'($urandom);
        w.cx = cx;
        w.cy = cy;
        push_word(w);
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_ENABLE: mask_on = data[0];
            REG_WIDTH:  mask_w = data;
            REG_HEIGHT: mask_h = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (words_taken != words_queued || cov_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                mask_step(cur_word);
                words_taken++;
            end
            if (!(i_start && o_busy)) begin
                if (idle_left > 0) begin
                    idle_left--;
                    i_start <= 1'b0;
                end else if (word_q.size() > 0) begin
                    cur_word = word_q.pop_front();
                    i_op <= cur_word.op;
                    i_texel_x <= cur_word.tx;
                    i_texel_y <= cur_word.ty;
                    i_texel_alpha <= cur_word.alpha;
                    i_coord_x <= cur_word.cx;
                    i_coord_y <= cur_word.cy;
                    i_start <= 1'b1;
                    idle_left = draw_idle();
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        logic [COV_W-1:0] want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (cov_due.size() == 0) begin
                report_fault($sformatf("coverage word %0d with none expected", o_coverage));
            end else begin
                want = cov_due.pop_front();
                if (o_coverage !== want)
                    report_fault($sformatf("coverage %0d, expected %0d", o_coverage, want));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // mask disabled after reset: full coverage
        push_sample(COORD_W'(-32768), COORD_W'(32767));
        push_sample(COORD_W'(0), COORD_W'(0));
        push_write(TEX_W'(255), TEX_W'(255), ALPHA_W'(255));
        drain();

        // zero width, then zero height
        cfg_write(REG_ENABLE, SIZE_W'(1));
        cfg_write(REG_HEIGHT, SIZE_W'(2));
        push_sample(COORD_W'(0), COORD_W'(0));
        drain();
        cfg_write(REG_WIDTH, SIZE_W'(3));
        cfg_write(REG_HEIGHT, SIZE_W'(0));
        push_sample(COORD_W'(16384), COORD_W'(-16384));
        drain();

        // 2x2 mask: corners, centre, saturation, write outside the mask size
        cfg_write(REG_HEIGHT, SIZE_W'(2));
        cfg_write(REG_WIDTH, SIZE_W'(2));
        push_write(TEX_W'(0), TEX_W'(0), ALPHA_W'(0));
        push_write(TEX_W'(1), TEX_W'(0), ALPHA_W'(255));
        push_write(TEX_W'(0), TEX_W'(1), ALPHA_W'(255));
        push_write(TEX_W'(1), TEX_W'(1), ALPHA_W'(128));
        push_sample(COORD_W'(-16384), COORD_W'(-16384));
        push_sample(COORD_W'(16384), COORD_W'(16384));
        push_sample(COORD_W'(0), COORD_W'(0));
        push_sample(COORD_W'(-32768), COORD_W'(32767));
        push_sample(COORD_W'(-16385), COORD_W'(16385));
        push_sample(COORD_W'(8192), COORD_W'(-8192));
        push_write(TEX_W'(200), TEX_W'(7), ALPHA_W'(77));
        drain();

        // sizes beyond the store clamp to its edge
        cfg_write(REG_WIDTH, SIZE_W'(511));
        cfg_write(REG_HEIGHT, SIZE_W'(300));
        cfg_write(REG_SPARE, SIZE_W'(511));
        push_sample(COORD_W'(16384), COORD_W'(16384));
        push_sample(COORD_W'(-16384), COORD_W'(-16384));
        push_sample(COORD_W'(0), COORD_W'(0));
        drain();

        while (words_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 4) != 0)
                cfg_write(REG_ENABLE, {ALPHA_W'($urandom), 1'($urandom_range(0, 9) != 0)});
            if ($urandom_range(0, 3) != 0) cfg_write(REG_WIDTH, draw_size());
            if ($urandom_range(0, 3) != 0) cfg_write(REG_HEIGHT, draw_size());
            if ($urandom_range(0, 9) == 0) cfg_write(REG_SPARE, SIZE_W'($urandom));
            gap_mode = $urandom_range(0, 2);
            n = $urandom_range(20, 120);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0)
                    push_write(TEX_W'($urandom), TEX_W'($urandom), draw_alpha());
                else
                    push_sample(draw_coord(), draw_coord());
            end
            drain();
        end

        if (faults == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
